// ----- rtl/core/pcrg_pkg.sv -----
`timescale 1ns / 1ps
package pcrg_pkg;

    // Field widths
    localparam int PIX_W     = 12;
    localparam int NDC_SHIFT = 15;
    localparam int DIV_STEPS = PIX_W + NDC_SHIFT;

    // Newton steps of the reciprocal square root
    localparam int RSQRT_ITERATIONS = 3;

    // Arithmetic constants
    localparam logic signed [27:0] NDC_BIAS   = 28'sd16384;
    localparam logic [32:0]        SEVEN_Q30  = 33'h1C0000000;
    localparam logic [33:0]        THREE_Q30  = 34'h0C0000000;
    localparam logic [31:0]        RECIP3     = 32'hAAAAAAAB;
    localparam logic signed [47:0] DIR_MAX    = 48'sd16384;
    localparam logic signed [47:0] DIR_MIN    = -48'sd16384;

    // Register reset values
    localparam logic [12:0] RST_WIDTH  = 13'd1280;
    localparam logic [12:0] RST_HEIGHT = 13'd720;
    localparam logic [15:0] RST_HTAN   = 16'd1697;
    localparam logic [15:0] RST_ASPECT = 16'd7282;

    // Register map
    typedef enum logic [2:0] {
        REG_CAM_POS = 3'd0,
        REG_FRONT   = 3'd1,
        REG_RIGHT   = 3'd2,
        REG_UP      = 3'd3,
        REG_WIDTH   = 3'd4,
        REG_HEIGHT  = 3'd5,
        REG_HTAN    = 3'd6,
        REG_ASPECT  = 3'd7
    } t_reg_idx;

    // Camera settings seen by the direction stages
    typedef struct packed {
        logic [47:0] front;
        logic [47:0] right;
        logic [47:0] up;
        logic [19:0] kx;
        logic [15:0] ht;
    } t_dir_cfg;

    // Side data that travels with the reciprocal square root
    typedef struct packed {
        logic [2:0][15:0] ds;
        logic [3:0]       q;
        logic [31:0]      m;
    } t_nrm;

endpackage

// ----- rtl/core/pcrg_if.sv -----
`timescale 1ns / 1ps
interface pcrg_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface pcrg_ray_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    output dir_x, output dir_y, output dir_z, input ready);
    modport sink (input valid, input origin_x, input origin_y, input origin_z,
                  input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ----- rtl/core/pcrg_div.sv -----
`timescale 1ns / 1ps
module pcrg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [11:0]        i_px,
    input  logic [11:0]        i_py,
    input  logic [12:0]        i_wid,
    input  logic [12:0]        i_hgt,
    output logic               o_vld,
    output logic signed [27:0] o_ndc_x,
    output logic signed [27:0] o_ndc_y
);
    import pcrg_pkg::*;

    logic                 r_vld   [DIV_STEPS];
    logic [12:0]          r_rem_x [DIV_STEPS];
    logic [12:0]          r_rem_y [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_num_x [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_num_y [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo_x [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo_y [DIV_STEPS];

    // One quotient bit per stage for each axis
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic                 vld_in;
        logic [12:0]          rem_x_in, rem_y_in;
        logic [DIV_STEPS-1:0] num_x_in, num_y_in, quo_x_in, quo_y_in;
        logic [13:0]          trial_x, trial_y;
        logic                 ge_x, ge_y;

        if (g == 0) begin : g_first
            assign vld_in   = i_vld;
            assign rem_x_in = '0;
            assign rem_y_in = '0;
            assign num_x_in = {i_px, {NDC_SHIFT{1'b0}}};
            assign num_y_in = {i_py, {NDC_SHIFT{1'b0}}};
            assign quo_x_in = '0;
            assign quo_y_in = '0;
        end else begin : g_next
            assign vld_in   = r_vld[g-1];
            assign rem_x_in = r_rem_x[g-1];
            assign rem_y_in = r_rem_y[g-1];
            assign num_x_in = r_num_x[g-1];
            assign num_y_in = r_num_y[g-1];
            assign quo_x_in = r_quo_x[g-1];
            assign quo_y_in = r_quo_y[g-1];
        end

        // Shift in the next dividend bit and try the subtract
        assign trial_x = {rem_x_in, num_x_in[DIV_STEPS-1]};
        assign trial_y = {rem_y_in, num_y_in[DIV_STEPS-1]};
        assign ge_x    = trial_x >= {1'b0, i_wid};
        assign ge_y    = trial_y >= {1'b0, i_hgt};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[g] <= ge_x ? 13'(trial_x - {1'b0, i_wid}) : trial_x[12:0];
                r_rem_y[g] <= ge_y ? 13'(trial_y - {1'b0, i_hgt}) : trial_y[12:0];
                r_num_x[g] <= {num_x_in[DIV_STEPS-2:0], 1'b0};
                r_num_y[g] <= {num_y_in[DIV_STEPS-2:0], 1'b0};
                r_quo_x[g] <= {quo_x_in[DIV_STEPS-2:0], ge_x};
                r_quo_y[g] <= {quo_y_in[DIV_STEPS-2:0], ge_y};
            end
        end
    end

    // Remove the bias to center the coordinate
    assign o_vld   = r_vld[DIV_STEPS-1];
    assign o_ndc_x = $signed({1'b0, r_quo_x[DIV_STEPS-1]}) - NDC_BIAS;
    assign o_ndc_y = $signed({1'b0, r_quo_y[DIV_STEPS-1]}) - NDC_BIAS;

endmodule

// ----- rtl/core/pcrg_dir.sv -----
`timescale 1ns / 1ps
module pcrg_dir (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [27:0] i_ndc_x,
    input  logic signed [27:0] i_ndc_y,
    input  pcrg_pkg::t_dir_cfg i_cfg,
    output logic               o_vld,
    output logic [31:0]        o_s,
    output logic [2:0][15:0]   o_ds
);
    import pcrg_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] res;
        if (v > 49'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -49'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic [8:0]         r_vld;
    logic signed [48:0] r_prod_x;
    logic signed [44:0] r_prod_y;
    logic signed [31:0] r_sx, r_sy;
    logic signed [47:0] r_pr [3];
    logic signed [47:0] r_pu [3];
    logic signed [35:0] r_d4 [3];
    logic signed [35:0] r_d5 [3];
    logic signed [35:0] r_d6 [3];
    logic [35:0]        r_or;
    logic [4:0]         r_k;
    logic signed [15:0] r_ds7 [3];
    logic signed [15:0] r_ds8 [3];
    logic [31:0]        r_sq [3];
    logic [31:0]        r_s;
    logic [2:0][15:0]   r_ds9;

    logic [35:0] w_abs [3];
    logic [5:0]  w_blen;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[7:0], i_vld};
        end
    end

    // Magnitudes of the combined direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_d4[i][35] ? 36'(-r_d4[i]) : 36'(r_d4[i]);
        end
    end

    // Bit length of the largest magnitude
    always_comb begin
        w_blen = '0;
        for (int b = 0; b < 36; b++) begin
            if (r_or[b]) begin
                w_blen = 6'(b + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Scale the centered coordinates
            r_prod_x <= 49'(i_ndc_x) * 49'($signed({1'b0, i_cfg.kx}));
            r_prod_y <= 45'(i_ndc_y) * 45'($signed({1'b0, i_cfg.ht}));
            r_sx     <= sat32(r_prod_x >>> 12);
            r_sy     <= sat32(49'(r_prod_y >>> 12));
            // Weight the basis vectors
            for (int i = 0; i < 3; i++) begin
                r_pr[i] <= 48'($signed(i_cfg.right[16*i +: 16])) * 48'(r_sx);
                r_pu[i] <= 48'($signed(i_cfg.up[16*i +: 16])) * 48'(r_sy);
                r_d4[i] <= 36'($signed(i_cfg.front[16*i +: 16]))
                           + 36'(r_pr[i] >>> 14) + 36'(r_pu[i] >>> 14);
                r_d5[i] <= r_d4[i];
                r_d6[i] <= r_d5[i];
                r_ds7[i] <= 16'(r_d6[i] >>> r_k);
                r_ds8[i] <= r_ds7[i];
                r_sq[i]  <= 32'(32'(r_ds7[i]) * 32'(r_ds7[i]));
                r_ds9[i] <= r_ds8[i];
            end
            r_or <= w_abs[0] | w_abs[1] | w_abs[2];
            r_k  <= (w_blen > 6'd15) ? 5'(w_blen - 6'd15) : 5'd0;
            r_s  <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_vld = r_vld[8];
    assign o_s   = r_s;
    assign o_ds  = r_ds9;

endmodule

// ----- rtl/core/pcrg_newton.sv -----
`timescale 1ns / 1ps
module pcrg_newton (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [31:0]    i_y,
    input  pcrg_pkg::t_nrm i_ctx,
    output logic           o_vld,
    output logic [31:0]    o_y,
    output pcrg_pkg::t_nrm o_ctx
);
    import pcrg_pkg::*;

    logic [3:0]  r_vld;
    logic [31:0] r_ya, r_yb, r_yc, r_y;
    logic [63:0] r_yy, r_t;
    logic [31:0] r_f;
    t_nrm        r_ca, r_cb, r_cc, r_cd;

    logic [31:0] w_y2;
    logic [33:0] w_t;
    logic [63:0] w_yf;

    assign w_y2 = r_yy[61:30];
    assign w_t  = r_t[63:30];
    assign w_yf = 64'(r_yc) * 64'(r_f);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // y*y, then m*y2, then the correction factor, then the update
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yy <= 64'(i_y) * 64'(i_y);
            r_ya <= i_y;
            r_ca <= i_ctx;
            r_t  <= 64'(r_ca.m) * 64'(w_y2);
            r_yb <= r_ya;
            r_cb <= r_ca;
            r_f  <= (w_t > THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - w_t);
            r_yc <= r_yb;
            r_cc <= r_cb;
            r_y  <= w_yf[62:31];
            r_cd <= r_cc;
        end
    end

    assign o_vld = r_vld[3];
    assign o_y   = r_y;
    assign o_ctx = r_cd;

endmodule

// ----- rtl/core/pcrg_rsqrt.sv -----
`timescale 1ns / 1ps
module pcrg_rsqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [31:0]      i_s,
    input  logic [2:0][15:0] i_ds,
    output logic             o_vld,
    output logic [2:0][15:0] o_dir
);
    import pcrg_pkg::*;

    logic [5:0]         r_vld;
    logic [31:0]        r_s1;
    logic [3:0]         r_q1;
    logic [2:0][15:0]   r_ds1;
    t_nrm               r_c2, r_c3, r_c4;
    logic [31:0]        r_h3;
    logic [63:0]        r_p4;
    logic signed [47:0] r_pd [3];
    logic [3:0]         r_qf;
    logic [2:0][15:0]   r_dir;

    logic [5:0]  w_blen;
    logic [3:0]  w_q;
    logic [4:0]  w_sh;
    logic [5:0]  w_dsh;
    logic        w_it_vld [RSQRT_ITERATIONS+1];
    logic [31:0] w_it_y   [RSQRT_ITERATIONS+1];
    t_nrm        w_it_ctx [RSQRT_ITERATIONS+1];
    logic signed [47:0] w_v [3];

    // Exponent: half of one less than the bit length of the sum of squares, rounded down
    always_comb begin
        w_blen = '0;
        for (int b = 0; b < 32; b++) begin
            if (i_s[b]) begin
                w_blen = 6'(b + 1);
            end
        end
        w_q = (w_blen == 6'd0) ? 4'd0 : 4'((w_blen - 6'd1) >> 1);
    end

    assign w_sh = 5'd30 - {r_q1, 1'b0};

    // Advance valid bits of the front and back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4], w_it_vld[RSQRT_ITERATIONS], r_vld[2:0], i_vld};
        end
    end

    // Mantissa and first estimate (7 - m) / 6
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1    <= i_s;
            r_q1    <= w_q;
            r_ds1   <= i_ds;
            r_c2.m  <= r_s1 << w_sh;
            r_c2.q  <= r_q1;
            r_c2.ds <= r_ds1;
            r_h3    <= 32'((SEVEN_Q30 - {1'b0, r_c2.m}) >> 1);
            r_c3    <= r_c2;
            r_p4    <= 64'(r_h3) * 64'(RECIP3);
            r_c4    <= r_c3;
        end
    end

    assign w_it_vld[0] = r_vld[3];
    assign w_it_y[0]   = 32'(r_p4[63:33]);
    assign w_it_ctx[0] = r_c4;

    // Newton refinement chain
    for (genvar g = 0; g < RSQRT_ITERATIONS; g++) begin : g_iter
        pcrg_newton u_newton (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (w_it_vld[g]),
            .i_y     (w_it_y[g]),
            .i_ctx   (w_it_ctx[g]),
            .o_vld   (w_it_vld[g+1]),
            .o_y     (w_it_y[g+1]),
            .o_ctx   (w_it_ctx[g+1])
        );
    end

    // Scale, shift down and clamp each component
    assign w_dsh = 6'd16 + {2'b00, r_qf};
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = r_pd[i] >>> w_dsh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qf <= w_it_ctx[RSQRT_ITERATIONS].q;
            for (int i = 0; i < 3; i++) begin
                r_pd[i] <= 48'($signed(w_it_ctx[RSQRT_ITERATIONS].ds[i]))
                           * 48'($signed({1'b0, w_it_y[RSQRT_ITERATIONS]}));
                if (w_v[i] > DIR_MAX) begin
                    r_dir[i] <= 16'(DIR_MAX);
                end else if (w_v[i] < DIR_MIN) begin
                    r_dir[i] <= 16'(DIR_MIN);
                end else begin
                    r_dir[i] <= w_v[i][15:0];
                end
            end
        end
    end

    assign o_vld = r_vld[5];
    assign o_dir = r_dir;

endmodule

// ----- rtl/core/pinhole_camera_ray_generation.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// i_pix     in   valid/ready            pixel_x, pixel_y (12 b each)
// o_ray     out  valid/ready            origin_x/y/z (Q8.8), dir_x/y/z (Q1.14)
// APB       in   psel/penable, pready=1 8 registers at 8*i, 64-bit data
//
// One ray per cycle is accepted while the skid register is empty. The pipeline
// holds 27 divider steps, 9 direction stages, 4 setup stages, 4 per Newton step,
// 2 scaling stages and 1 output register, with three Newton steps.
// Reset is synchronous, active low; it clears valid bits and loads register defaults.
// A full output register with ready low parks the next ray in a skid register;
// the pipeline holds only while that skid register is occupied.
module pinhole_camera_ray_generation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    pcrg_pix_if.sink    i_pix,
    pcrg_ray_if.source  o_ray
);
    import pcrg_pkg::*;

    logic [47:0] r_cam, r_front, r_right, r_up;
    logic [12:0] r_wid, r_hgt;
    logic [15:0] r_htan, r_aspect;
    logic [19:0] r_kx;

    logic             r_out_vld, r_sk_vld;
    logic [2:0][15:0] r_out, r_sk;

    logic               w_en;
    logic [12:0]        w_wid, w_hgt;
    logic [31:0]        w_kprod;
    t_dir_cfg           w_cfg;
    logic               w_div_vld, w_dir_vld, w_pipe_vld;
    logic signed [27:0] w_ndc_x, w_ndc_y;
    logic [31:0]        w_s;
    logic [2:0][15:0]   w_ds, w_dir;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam    <= '0;
            r_front  <= '0;
            r_right  <= '0;
            r_up     <= '0;
            r_wid    <= RST_WIDTH;
            r_hgt    <= RST_HEIGHT;
            r_htan   <= RST_HTAN;
            r_aspect <= RST_ASPECT;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_CAM_POS: r_cam    <= pwdata[47:0];
                REG_FRONT:   r_front  <= pwdata[47:0];
                REG_RIGHT:   r_right  <= pwdata[47:0];
                REG_UP:      r_up     <= pwdata[47:0];
                REG_WIDTH:   r_wid    <= pwdata[12:0];
                REG_HEIGHT:  r_hgt    <= pwdata[12:0];
                REG_HTAN:    r_htan   <= pwdata[15:0];
                REG_ASPECT:  r_aspect <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_CAM_POS: prdata = 64'(r_cam);
            REG_FRONT:   prdata = 64'(r_front);
            REG_RIGHT:   prdata = 64'(r_right);
            REG_UP:      prdata = 64'(r_up);
            REG_WIDTH:   prdata = 64'(r_wid);
            REG_HEIGHT:  prdata = 64'(r_hgt);
            REG_HTAN:    prdata = 64'(r_htan);
            REG_ASPECT:  prdata = 64'(r_aspect);
            default:     prdata = '0;
        endcase
    end

    // Horizontal scale, aspect times half tangent
    assign w_kprod = 32'(r_aspect) * 32'(r_htan);
    always_ff @(posedge i_clk) begin
        r_kx <= w_kprod[31:12];
    end

    // A zero size divides as one
    assign w_wid = (r_wid == 13'd0) ? 13'd1 : r_wid;
    assign w_hgt = (r_hgt == 13'd0) ? 13'd1 : r_hgt;

    assign w_cfg.front = r_front;
    assign w_cfg.right = r_right;
    assign w_cfg.up    = r_up;
    assign w_cfg.kx    = r_kx;
    assign w_cfg.ht    = r_htan;

    assign w_en        = !r_sk_vld;
    assign i_pix.ready = w_en;

    pcrg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pix.valid),
        .i_px    (i_pix.pixel_x),
        .i_py    (i_pix.pixel_y),
        .i_wid   (w_wid),
        .i_hgt   (w_hgt),
        .o_vld   (w_div_vld),
        .o_ndc_x (w_ndc_x),
        .o_ndc_y (w_ndc_y)
    );

    pcrg_dir u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_ndc_x (w_ndc_x),
        .i_ndc_y (w_ndc_y),
        .i_cfg   (w_cfg),
        .o_vld   (w_dir_vld),
        .o_s     (w_s),
        .o_ds    (w_ds)
    );

    pcrg_rsqrt u_rsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dir_vld),
        .i_s     (w_s),
        .i_ds    (w_ds),
        .o_vld   (w_pipe_vld),
        .o_dir   (w_dir)
    );

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (r_sk_vld) begin
            if (o_ray.ready) begin
                r_sk_vld <= 1'b0;
            end
        end else if (!r_out_vld || o_ray.ready) begin
            r_out_vld <= w_pipe_vld;
        end else if (w_pipe_vld) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (o_ray.ready) begin
                r_out <= r_sk;
            end
        end else if (!r_out_vld || o_ray.ready) begin
            r_out <= w_dir;
        end else begin
            r_sk <= w_dir;
        end
    end

    assign o_ray.valid    = r_out_vld;
    assign o_ray.origin_x = $signed(r_cam[15:0]);
    assign o_ray.origin_y = $signed(r_cam[31:16]);
    assign o_ray.origin_z = $signed(r_cam[47:32]);
    assign o_ray.dir_x    = $signed(r_out[0]);
    assign o_ray.dir_y    = $signed(r_out[1]);
    assign o_ray.dir_z    = $signed(r_out[2]);

endmodule
